/* hw/rtl/swa_pkg.sv */
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types, widths and helpers for the sliding window autocorrelation.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int WINDOW  = 100;
    localparam int MAX_LAG = 15;
    localparam int AW      = $clog2(WINDOW);   // window address
    localparam int CW      = AW + 1;           // samples-seen counter
    localparam int LW      = 4;                // lag count register
    localparam int SW      = 16;               // sample
    localparam int SUMW    = 23;               // running sum, signed
    localparam int DW      = 24;               // scaled deviation, signed
    localparam int PW      = 2 * DW;           // product, signed
    localparam int SQW     = 54;               // sum of squares, unsigned
    localparam int NUMW    = 60;               // lag product sum, signed
    localparam int DENW    = SQW + LW;         // lag count times sum of squares
    localparam int FW      = 16;               // feature
    localparam int QCW     = $clog2(FW + 1);   // quotient bit counter

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_VAR,
        S_LAG,
        S_DRAIN,
        S_DEN,
        S_DIVGO,
        S_DIVW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic            start;
        logic [NUMW-1:0] num;
        logic [DENW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [FW-1:0] quot;
    } t_div_rsp;

    // circular window address increment
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(WINDOW - 1)) begin
            r = '0;
        end else begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    // WINDOW * x - sum, exact in DW bits
    function automatic logic signed [DW-1:0] scaled_dev(input logic [SW-1:0] x,
                                                         input logic [SUMW-1:0] s);
        logic signed [DW-1:0] xe;
        logic signed [DW-1:0] se;
        xe = $signed({{(DW-SW){x[SW-1]}}, x});
        se = $signed({{(DW-SUMW){s[SUMW-1]}}, s});
        return (xe <<< 6) + (xe <<< 5) + (xe <<< 2) - se;
    endfunction

endpackage

/* hw/rtl/swa_in_if.sv */
// ----------------------------------------------------------------------------
// swa_in_if
// Sample request channel: valid/ready with one signed 16-bit sample.
// ----------------------------------------------------------------------------
interface swa_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hw/rtl/swa_out_if.sv */
// ----------------------------------------------------------------------------
// swa_out_if
// Result request channel: feature plus window status flags.
// ----------------------------------------------------------------------------
interface swa_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] feature;
    logic        window_full;
    logic        flat_window;

    modport source (output valid, output feature, output window_full,
                    output flat_window, input ready);
    modport sink   (input valid, input feature, input window_full,
                    input flat_window, output ready);
endinterface

/* hw/rtl/swa_div.sv */
// ----------------------------------------------------------------------------
// swa_div
// Restoring divider: one quotient bit per cycle, saturates when num >= den.
// ----------------------------------------------------------------------------
module swa_div
    import swa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic            r_busy;
    logic [QCW-1:0]  r_cnt;
    logic [NUMW-1:0] r_rem;
    logic [DENW-1:0] r_den;
    logic [FW-1:0]   r_quot;
    logic            r_done;
    logic [NUMW-1:0] n_rem_sh;
    logic            n_take;

    assign n_rem_sh = r_rem << 1;
    assign n_take   = n_rem_sh >= NUMW'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_den <= i_req.den;
                if (i_req.num >= NUMW'(i_req.den)) begin
                    r_quot <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_req.num;
                    r_quot <= '0;
                    r_cnt  <= QCW'(FW);
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= n_take ? n_rem_sh - NUMW'(r_den) : n_rem_sh;
                r_quot <= {r_quot[FW-2:0], n_take};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == QCW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start) else $error("divider restarted while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0 && r_cnt <= QCW'(FW))) else $error("bad bit count");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done) else $error("busy dropped without done");

endmodule

/* hw/rtl/sliding_window_autocorrelation.sv */
// ----------------------------------------------------------------------------
// sliding_window_autocorrelation
// Mean autocorrelation over lags 1..lag_count of the last 100 samples.
// ----------------------------------------------------------------------------
// Flow: while the window fills, a request passes the update and done states only;
//   once more than 100 samples are seen, a variance pass, the lag rows and a drain
//   run before the divide; a saturating ratio skips the 16 divide steps.
// Throughput: one request at a time, the next taken the cycle after the
//   result loads; the single multiply-accumulate over the window sets the rate.
// Reset: synchronous active low; clears sum, pointer, count, lag_count = 15.
// ----------------------------------------------------------------------------
module sliding_window_autocorrelation
    import swa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [LW-1:0] i_cfg_wdata,
    swa_in_if.sink        i_in,
    swa_out_if.source     o_out
);

    // ---------------- control state
    t_state          r_state, n_state;
    logic [LW-1:0]   r_lag_count;
    logic [LW-1:0]   r_lags;         // effective lag count for this request
    logic [SUMW-1:0] r_sum;
    logic [AW-1:0]   r_wp;           // next write slot == oldest sample
    logic [CW-1:0]   r_seen;
    logic [CW-1:0]   n_seen;
    logic [SW-1:0]   r_sample;

    // ---------------- address walk
    logic [AW-1:0]   r_pa, r_pb;     // read addresses, port A and B
    logic [AW-1:0]   r_kstart;       // first B address of current lag row
    logic [AW-1:0]   r_i;
    logic [LW-1:0]   r_k;

    // ---------------- window memory, two registered read ports
    logic [SW-1:0]   mem [WINDOW];
    logic [SW-1:0]   r_rda, r_rdb;

    // ---------------- MAC pipeline
    logic            r_v1, r_v2, r_v3;
    logic            r_lag1, r_lag2, r_lag3;
    logic signed [DW-1:0] r_da, r_db;
    logic signed [PW-1:0] r_prod;
    logic [SQW-1:0]  r_sq;
    logic signed [NUMW-1:0] r_num;

    // ---------------- finish
    logic [NUMW-1:0] r_numabs;
    logic [DENW-1:0] r_den;
    logic            r_flat;
    t_div_req        div_req;
    t_div_rsp        div_rsp;

    // ---------------- result being built, kept apart from the held result
    logic [FW-1:0]   r_res_feat;
    logic            r_res_full;
    logic            r_res_flat;

    // ---------------- result register
    logic            r_ovalid;
    logic [FW-1:0]   r_feat;
    logic            r_full;
    logic            r_oflat;

    // FSM decodes
    logic accept, issue, row_end, ld_out;

    assign accept  = i_in.valid && i_in.ready;
    assign n_seen  = (r_seen < CW'(WINDOW + 1)) ? r_seen + 1'b1 : r_seen;
    assign row_end = (r_i == AW'(WINDOW - 1) - AW'(r_k));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_UPD;
            S_UPD:   n_state = (n_seen > CW'(WINDOW)) ? S_VAR : S_DONE;
            S_VAR:   if (r_i == AW'(WINDOW - 1)) n_state = S_LAG;
            S_LAG:   if (row_end && r_k == r_lags) n_state = S_DRAIN;
            S_DRAIN: if (!r_v1 && !r_v2 && !r_v3) n_state = S_DEN;
            S_DEN:   n_state = S_DIVGO;
            S_DIVGO: n_state = S_DIVW;
            S_DIVW:  if (div_rsp.done) n_state = S_DONE;
            S_DONE:  if (!r_ovalid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready    = 1'b0;
        issue         = 1'b0;
        ld_out        = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = r_numabs;
        div_req.den   = r_den;
        unique case (r_state)
            S_IDLE:  i_in.ready = 1'b1;
            S_VAR,
            S_LAG:   issue = 1'b1;
            S_DIVGO: div_req.start = 1'b1;
            S_DONE:  ld_out = !r_ovalid || o_out.ready;
            default: ;
        endcase
    end

    // memory: write on update, reads every cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            mem[r_wp] <= r_sample;
        end
        r_rda <= mem[r_pa];
        r_rdb <= mem[r_pb];
    end

    // datapath without reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_in.sample;
        end
        r_da   <= scaled_dev(r_rda, r_sum);
        r_db   <= scaled_dev(r_rdb, r_sum);
        r_prod <= r_da * r_db;
        if (r_state == S_DEN) begin
            r_den    <= DENW'(r_sq) * DENW'(r_lags);
            r_numabs <= r_num[NUMW-1] ? NUMW'(-r_num) : NUMW'(r_num);
            r_flat   <= (r_sq == '0);
        end
    end

    // control and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lag_count <= LW'(MAX_LAG);
            r_lags      <= LW'(MAX_LAG);
            r_sum       <= '0;
            r_wp        <= '0;
            r_seen      <= '0;
            r_pa        <= '0;
            r_pb        <= '0;
            r_kstart    <= '0;
            r_i         <= '0;
            r_k         <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_lag1      <= 1'b0;
            r_lag2      <= 1'b0;
            r_lag3      <= 1'b0;
            r_sq        <= '0;
            r_num       <= '0;
            r_res_feat  <= '0;
            r_res_full  <= 1'b0;
            r_res_flat  <= 1'b0;
            r_ovalid    <= 1'b0;
            r_feat      <= '0;
            r_full      <= 1'b0;
            r_oflat     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lag_count <= i_cfg_wdata;
            end

            // MAC pipeline valids
            r_v1   <= issue;
            r_lag1 <= (r_state == S_LAG);
            r_v2   <= r_v1;
            r_lag2 <= r_lag1;
            r_v3   <= r_v2;
            r_lag3 <= r_lag2;
            if (r_v3) begin
                if (r_lag3) begin
                    r_num <= r_num + NUMW'(r_prod);
                end else begin
                    r_sq <= r_sq + SQW'($unsigned(r_prod));
                end
            end

            unique case (r_state)
                S_UPD: begin
                    // r_rda holds the slot about to be overwritten
                    r_sum <= r_sum
                           - ((r_seen >= CW'(WINDOW))
                              ? SUMW'($signed(r_rda)) : SUMW'(0))
                           + SUMW'($signed(r_sample));
                    r_wp   <= wrap_inc(r_wp);
                    r_pa   <= wrap_inc(r_wp);
                    r_pb   <= wrap_inc(r_wp);
                    r_seen <= n_seen;
                    r_i    <= '0;
                    r_sq   <= '0;
                    r_num  <= '0;
                    r_lags <= (r_lag_count == '0) ? LW'(1) : r_lag_count;
                    r_res_feat <= '0;
                    r_res_full <= 1'b0;
                    r_res_flat <= 1'b0;
                end
                S_VAR: begin
                    if (r_i == AW'(WINDOW - 1)) begin
                        r_i      <= '0;
                        r_k      <= LW'(1);
                        r_pa     <= r_wp;
                        r_pb     <= wrap_inc(r_wp);
                        r_kstart <= wrap_inc(r_wp);
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_pa <= wrap_inc(r_pa);
                        r_pb <= wrap_inc(r_pb);
                    end
                end
                S_LAG: begin
                    if (row_end) begin
                        r_i      <= '0;
                        r_k      <= r_k + 1'b1;
                        r_pa     <= r_wp;
                        r_pb     <= wrap_inc(r_kstart);
                        r_kstart <= wrap_inc(r_kstart);
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_pa <= wrap_inc(r_pa);
                        r_pb <= wrap_inc(r_pb);
                    end
                end
                S_DIVW: begin
                    if (div_rsp.done) begin
                        r_res_feat <= r_flat ? FW'(0) : div_rsp.quot;
                        r_res_full <= 1'b1;
                        r_res_flat <= r_flat;
                    end
                end
                S_DONE: begin
                    // park port A on the oldest slot for the next update
                    r_pa <= r_wp;
                end
                default: ;
            endcase

            // result register only changes when it is empty or being taken
            if (ld_out) begin
                r_ovalid <= 1'b1;
                r_feat   <= r_res_feat;
                r_full   <= r_res_full;
                r_oflat  <= r_res_flat;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    swa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out.valid       = r_ovalid;
    assign o_out.feature     = r_feat;
    assign o_out.window_full = r_full;
    assign o_out.flat_window = r_oflat;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp < AW'(WINDOW)) && (r_pa < AW'(WINDOW)) && (r_pb < AW'(WINDOW)))
        else $error("window address out of range");
    a_seen_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CW'(WINDOW + 1)) else $error("sample count overflow");
    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_UPD)) else $error("request not taken to update");
    a_flat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oflat) |-> (r_full && r_feat == '0))
        else $error("flat window result inconsistent");
    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEN) |-> (!r_v1 && !r_v2 && !r_v3))
        else $error("finish began with products in flight");

endmodule
